[src/octree_cell_index_for_box_defines.svh]
// Assertion macros for the octree cell index block.
// Taken in by `include from the RTL files that assert; depends on nothing else.
`ifndef OCTREE_CELL_INDEX_FOR_BOX_DEFINES_SVH
`define OCTREE_CELL_INDEX_FOR_BOX_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define OCIB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ocib: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define OCIB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ocib: next-cycle check failed");
`else
`define OCIB_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define OCIB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[src/ocib_pkg.sv]
// Shared types, register indexes and the level-base table of the octree cell index block.
// Used by ocib_grid, ocib_cell and octree_cell_index_for_box; depends on nothing.
package ocib_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TREE_LEVELS = 3'd6;

  typedef struct packed {
    logic signed [31:0] lo_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_x;
    logic signed [31:0] hi_y;
    logic signed [31:0] hi_z;
  } in_word_t;

  typedef struct packed {
    logic [21:0] cell_index;
    logic [2:0]  cell_depth;
    logic        index_valid;
  } out_word_t;

  // Per-stage load enables, one per pipeline register rank.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  // Cells in all levels above depth d: (8^d - 1) / 7.
  function automatic logic [21:0] level_base(input logic [3:0] d);
    logic [21:0] r;
    case (d)
      4'd0:    r = 22'd0;
      4'd1:    r = 22'd1;
      4'd2:    r = 22'd9;
      4'd3:    r = 22'd73;
      4'd4:    r = 22'd585;
      4'd5:    r = 22'd4681;
      4'd6:    r = 22'd37449;
      4'd7:    r = 22'd299593;
      4'd8:    r = 22'd2396745;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

[src/ocib_grid.sv]
// One corner coordinate to finest-grid coordinate: offset, scale, saturate (three stages).
// Depends on ocib_pkg for the stage enable struct.
module ocib_grid #(
  parameter int CW = 6
) (
  input  logic                clk,
  input  ocib_pkg::pipe_en_t  en,
  input  logic signed [31:0]  coord_i,
  input  logic signed [31:0]  origin_i,
  input  logic [31:0]         inv_i,
  input  logic [CW-1:0]       maxc_i,
  output logic [CW-1:0]       coord_o
);

  logic signed [32:0] diff;
  logic               pos_nxt;
  logic               pos_r;
  logic [31:0]        mag_r;
  logic [63:0]        prod;
  logic [31:0]        hi_nxt;
  logic [31:0]        hi_r;
  logic               sat;
  logic [CW-1:0]      coord_nxt;
  logic [CW-1:0]      coord_r;

  // Stage 1: exact 33-bit offset; only a strictly positive offset scales.
  always_comb begin
    diff    = {coord_i[31], coord_i} - {origin_i[31], origin_i};
    pos_nxt = !diff[32] && (diff[31:0] != 32'd0);
  end

  // Stage 2: Q16.16 times Q16.16, keep the integer part.
  assign prod   = {32'd0, mag_r} * {32'd0, inv_i};
  assign hi_nxt = pos_r ? prod[63:32] : 32'd0;

  // Stage 3: clamp to the top cell of the grid.
  assign sat       = hi_r > {{(32-CW){1'b0}}, maxc_i};
  assign coord_nxt = sat ? maxc_i : hi_r[CW-1:0];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag_r <= diff[31:0];
      pos_r <= pos_nxt;
    end
    if (en.s2) begin
      hi_r <= hi_nxt;
    end
    if (en.s3) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord_o = coord_r;

endmodule

[src/ocib_cell.sv]
// Morton interleave of both corners, depth search and linear cell index, into the out register.
// Depends on ocib_pkg for the result word and the level-base table.
module ocib_cell #(
  parameter int CW = 6
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [2:0][CW-1:0]    lo_c,
  input  logic [2:0][CW-1:0]    hi_c,
  input  logic [2:0]            lv,
  output ocib_pkg::out_word_t   word_o
);

  localparam int MW = 3 * CW;

  logic [MW-1:0]        lo_code;
  logic [MW-1:0]        hi_code;
  logic [MW-1:0]        diff;
  logic [2:0]           up;
  logic [2:0]           depth;
  logic [4:0]           shamt;
  logic [MW-1:0]        hi_shift;
  logic [22:0]          idx;
  logic [22:0]          total;
  logic                 valid;
  ocib_pkg::out_word_t  word_nxt;
  ocib_pkg::out_word_t  word_r;

  // x in bit 0, y in bit 1, z in bit 2 of each group.
  always_comb begin
    for (int i = 0; i < CW; i++) begin
      for (int k = 0; k < 3; k++) begin
        lo_code[3*i+k] = lo_c[k][i];
        hi_code[3*i+k] = hi_c[k][i];
      end
    end
  end

  assign diff = lo_code ^ hi_code;

  // Highest differing group below the active level count.
  always_comb begin
    up = 3'd0;
    for (int i = 0; i < CW; i++) begin
      if ((3'(i) < lv) && (diff[3*i +: 3] != 3'b000)) begin
        up = 3'(i + 1);
      end
    end
  end

  always_comb begin
    depth    = lv - up;
    shamt    = {2'b00, up} + {1'b0, up, 1'b0};
    hi_shift = hi_code >> shamt;
    idx      = {{(23-MW){1'b0}}, hi_shift}
             + {1'b0, ocib_pkg::level_base({1'b0, depth})};
    total    = {1'b0, ocib_pkg::level_base({1'b0, lv} + 4'd1)};
    valid    = idx < total;
    word_nxt.cell_index  = valid ? idx[21:0] : 22'd0;
    word_nxt.cell_depth  = depth;
    word_nxt.index_valid = valid;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

endmodule

[src/octree_cell_index_for_box.sv]
// Top level of the octree cell index block: config registers, pipeline control, datapath.
// Depends on ocib_pkg, ocib_grid, ocib_cell and octree_cell_index_for_box_defines.svh.

// Maps an axis-aligned box (min and max corners, signed Q16.16) to the one linear-octree
// cell that holds it. Each corner is offset by the region origin, scaled by the reciprocal
// cell width, truncated and clamped to 0..2^L-1 per axis, where L is tree_levels limited to
// MAX_LEVEL-1. The two Morton codes pick the depth from their highest differing 3-bit group,
// and the index is the max-corner code shifted up to that depth plus the cell count of all
// shallower levels. The pipeline is four register ranks deep: offset, 32x32 multiply (six
// multipliers, one per corner coordinate), clamp, then interleave/depth/index into the
// output register. Throughput is one word per cycle while the output is not stalled.
// Each rank holds its word until the next one frees up, so bubbles close
// and a stall on the output side backs up to in_stall only once every rank is full. There
// is no memory and no clearing pass; the block takes words right after reset. Write the
// configuration only while no word is in flight.
`include "octree_cell_index_for_box_defines.svh"

module octree_cell_index_for_box #(
  parameter int MAX_LEVEL = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ocib_pkg::in_word_t                  in_word,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output ocib_pkg::out_word_t                 out_word,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [ocib_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ocib_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Coordinate width per axis; at least one bit so the datapath stays legal.
  localparam int CW = (MAX_LEVEL > 1) ? (MAX_LEVEL - 1) : 1;
  localparam logic [3:0] LV_MAX = 4'(MAX_LEVEL - 1);

  // Configuration registers.
  logic signed [31:0] origin_r [3];
  logic [31:0]        inv_r [3];
  logic [2:0]         tree_levels_r;

  // Pipeline valid bits and readiness per rank.
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  ocib_pkg::pipe_en_t en;

  logic [2:0]           lv;
  logic [CW-1:0]        maxc;
  logic signed [31:0]   lo_in [3];
  logic signed [31:0]   hi_in [3];
  logic [2:0][CW-1:0]   lo_c;
  logic [2:0][CW-1:0]   hi_c;
  ocib_pkg::out_word_t  word;

  // Take configuration writes; drop indexes past the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0]   <= 32'sd0;
      origin_r[1]   <= 32'sd0;
      origin_r[2]   <= 32'sd0;
      inv_r[0]      <= 32'd65536;
      inv_r[1]      <= 32'd65536;
      inv_r[2]      <= 32'd65536;
      tree_levels_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_idx)
        ocib_pkg::REG_ORIGIN_X:    origin_r[0]   <= cfg_data;
        ocib_pkg::REG_ORIGIN_Y:    origin_r[1]   <= cfg_data;
        ocib_pkg::REG_ORIGIN_Z:    origin_r[2]   <= cfg_data;
        ocib_pkg::REG_INV_CELL_X:  inv_r[0]      <= cfg_data;
        ocib_pkg::REG_INV_CELL_Y:  inv_r[1]      <= cfg_data;
        ocib_pkg::REG_INV_CELL_Z:  inv_r[2]      <= cfg_data;
        ocib_pkg::REG_TREE_LEVELS: tree_levels_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Limit the level count; the grid top is 2^lv - 1 per axis.
  always_comb begin
    lv = ({1'b0, tree_levels_r} > LV_MAX) ? LV_MAX[2:0] : tree_levels_r;
    for (int i = 0; i < CW; i++) begin
      maxc[i] = 3'(i) < lv;
    end
  end

  // A rank loads when it is empty or the rank after it moves on.
  always_comb begin
    rdy4 = !v4_r || !out_stall;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
    en.s1 = rdy1;
    en.s2 = rdy2;
    en.s3 = rdy3;
    en.s4 = rdy4;
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
    v4_nxt = rdy4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_stall = !rdy1;

  assign lo_in[0] = in_word.lo_x;
  assign lo_in[1] = in_word.lo_y;
  assign lo_in[2] = in_word.lo_z;
  assign hi_in[0] = in_word.hi_x;
  assign hi_in[1] = in_word.hi_y;
  assign hi_in[2] = in_word.hi_z;

  // One grid unit per corner coordinate.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    ocib_grid #(.CW(CW)) u_lo (
      .clk      (clk),
      .en       (en),
      .coord_i  (lo_in[a]),
      .origin_i (origin_r[a]),
      .inv_i    (inv_r[a]),
      .maxc_i   (maxc),
      .coord_o  (lo_c[a])
    );
    ocib_grid #(.CW(CW)) u_hi (
      .clk      (clk),
      .en       (en),
      .coord_i  (hi_in[a]),
      .origin_i (origin_r[a]),
      .inv_i    (inv_r[a]),
      .maxc_i   (maxc),
      .coord_o  (hi_c[a])
    );
  end

  ocib_cell #(.CW(CW)) u_cell (
    .clk    (clk),
    .load   (en.s4),
    .lo_c   (lo_c),
    .hi_c   (hi_c),
    .lv     (lv),
    .word_o (word)
  );

  assign out_valid = v4_r;
  assign out_word  = word;

  // An accepted word always lands in the first rank.
  `OCIB_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, v1_r)
  // Back-pressure reaches the input only with every rank full and the output held.
  `OCIB_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall, v1_r && v2_r && v3_r && v4_r && out_stall)
  // The chosen depth never lies below the finest active level.
  `OCIB_ASSERT_NOW(a_depth_range, clk, rst_n, out_valid, out_word.cell_depth <= lv)
  // A rejected index reads as zero.
  `OCIB_ASSERT_NOW(a_bad_index_zero, clk, rst_n, out_valid && !out_word.index_valid,
                   out_word.cell_index == 22'd0)

endmodule
